### sv/first_fit_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha check failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha check failed");

`endif

### sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Field widths, command and status codes, controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int CMD_W    = 2;
  localparam int KIND_W   = 8;
  localparam int SIZE_W   = 12;
  localparam int HANDLE_W = 12;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_VALIDATE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_NULL     = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

endpackage

### sv/ffha_cell.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator table cell
// Holds one table entry and passes it to its neighbor on shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_cell #(
  parameter int AW = 12
) (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [AW-1:0]               in_start,
  input  logic [ffha_pkg::SIZE_W-1:0] in_size,
  input  logic [ffha_pkg::KIND_W-1:0] in_kind,
  output logic [AW-1:0]               out_start,
  output logic [ffha_pkg::SIZE_W-1:0] out_size,
  output logic [ffha_pkg::KIND_W-1:0] out_kind
);

  logic [AW-1:0]               start_r;
  logic [ffha_pkg::SIZE_W-1:0] size_r;
  logic [ffha_pkg::KIND_W-1:0] kind_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      start_r <= in_start;
      size_r  <= in_size;
      kind_r  <= in_kind;
    end
  end

  assign out_start = start_r;
  assign out_size  = size_r;
  assign out_kind  = kind_r;

endmodule

### sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Each command makes a full rotation of the cell chain past the head
// controller; the result strobe comes after the rotation, and no new command
// is accepted until the controller is back in idle.
// Reset: synchronous, active low; clears entry count and control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 5,
  parameter int MAX_ENTRIES  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffha_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ffha_pkg::KIND_W-1:0]   in_alloc_type,
  input  logic [ffha_pkg::SIZE_W-1:0]   in_payload_size,
  input  logic [ffha_pkg::HANDLE_W-1:0] in_handle,
  input  logic                          in_handle_present,
  output logic                          out_valid,
  output logic [ffha_pkg::STATUS_W-1:0] out_status,
  output logic [ffha_pkg::HANDLE_W-1:0] out_result_handle,
  output logic [ffha_pkg::KIND_W-1:0]   out_found_type
);

  localparam int AW  = $clog2(HEAP_BYTES);
  localparam int EW  = $clog2(HEAP_BYTES + 1);
  localparam int NW  = ffha_pkg::SIZE_W + 1;
  localparam int SW  = ((EW > NW) ? EW : NW) + 1;
  localparam int KW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int HW  = (AW > ffha_pkg::HANDLE_W) ? AW : ffha_pkg::HANDLE_W;
  localparam logic [KW-1:0] K_LAST = KW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] C_FULL = CW'(MAX_ENTRIES);
  localparam logic [SW-1:0] S_HEAP = SW'(HEAP_BYTES);
  localparam logic [SW-1:0] S_HDR  = SW'(HEADER_BYTES);

  // chain wiring
  logic [AW-1:0]               c_start [MAX_ENTRIES];
  logic [ffha_pkg::SIZE_W-1:0] c_size  [MAX_ENTRIES];
  logic [ffha_pkg::KIND_W-1:0] c_kind  [MAX_ENTRIES];
  logic [AW-1:0]               n_start [MAX_ENTRIES];
  logic [ffha_pkg::SIZE_W-1:0] n_size  [MAX_ENTRIES];
  logic [ffha_pkg::KIND_W-1:0] n_kind  [MAX_ENTRIES];

  logic [AW-1:0]               push_start;
  logic [ffha_pkg::SIZE_W-1:0] push_size;
  logic [ffha_pkg::KIND_W-1:0] push_kind;
  logic                        shift;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign n_start[gi] = push_start;
        assign n_size[gi]  = push_size;
        assign n_kind[gi]  = push_kind;
      end else begin : g_mid
        assign n_start[gi] = c_start[gi+1];
        assign n_size[gi]  = c_size[gi+1];
        assign n_kind[gi]  = c_kind[gi+1];
      end
      ffha_cell #(.AW(AW)) u_cell (
        .clk       (clk),
        .shift     (shift),
        .in_start  (n_start[gi]),
        .in_size   (n_size[gi]),
        .in_kind   (n_kind[gi]),
        .out_start (c_start[gi]),
        .out_size  (c_size[gi]),
        .out_kind  (c_kind[gi])
      );
    end
  endgenerate

  // controller
  ffha_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  ffha_pkg::cmd_t              cmd_r;
  logic [ffha_pkg::KIND_W-1:0] kind_r;
  logic [ffha_pkg::SIZE_W-1:0] size_r;
  logic [AW-1:0]               handle_r;
  logic                        present_r;
  logic                        hbad_r;
  logic [EW-1:0]               end_r, end_nxt;
  logic                        found_r, found_nxt;
  logic [ffha_pkg::HANDLE_W-1:0] res_r, res_nxt;
  logic [ffha_pkg::KIND_W-1:0] hit_r, hit_nxt;
  logic [AW-1:0]               carry_start_r;
  logic [ffha_pkg::SIZE_W-1:0] carry_size_r;
  logic [ffha_pkg::KIND_W-1:0] carry_kind_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [ffha_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ffha_pkg::HANDLE_W-1:0] out_res_r, out_res_nxt;
  logic [ffha_pkg::KIND_W-1:0] out_type_r, out_type_nxt;

  logic          accept, live, at_tail, full, last;
  logic [SW-1:0] need, fit_end, h_end;
  logic [HW-1:0] handle_ext;

  assign accept  = start && (state_r == ffha_pkg::S_IDLE);
  assign busy    = (state_r != ffha_pkg::S_IDLE);
  assign shift   = (state_r == ffha_pkg::S_RUN);
  assign live    = CW'(k_r) < count_r;
  assign at_tail = CW'(k_r) == count_r;
  assign full    = count_r == C_FULL;
  assign last    = k_r == K_LAST;
  assign need    = S_HDR + SW'(size_r);
  assign fit_end = SW'(end_r) + need;
  assign h_end   = SW'(c_start[0]) + S_HDR + SW'(c_size[0]);
  assign handle_ext = HW'(in_handle);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    count_nxt  = count_r;
    end_nxt    = end_r;
    found_nxt  = found_r;
    res_nxt    = res_r;
    hit_nxt    = hit_r;
    push_start = c_start[0];
    push_size  = c_size[0];
    push_kind  = c_kind[0];
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_res_nxt    = out_res_r;
    out_type_nxt   = out_type_r;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = ffha_pkg::S_RUN;
          k_nxt     = '0;
          end_nxt   = '0;
          found_nxt = 1'b0;
          res_nxt   = '0;
          hit_nxt   = '0;
        end
      end
      ffha_pkg::S_RUN: begin
        case (cmd_r)
          ffha_pkg::CMD_CREATE: begin
            if (found_r) begin
              push_start = carry_start_r;
              push_size  = carry_size_r;
              push_kind  = carry_kind_r;
            end else if (!full && ((live && (SW'(c_start[0]) >= fit_end)) ||
                                   (at_tail && (fit_end <= S_HEAP)))) begin
              found_nxt  = 1'b1;
              res_nxt    = ffha_pkg::HANDLE_W'(end_r);
              push_start = AW'(end_r);
              push_size  = size_r;
              push_kind  = kind_r;
            end else if (live) begin
              end_nxt = EW'(h_end);
            end
          end
          ffha_pkg::CMD_DELETE: begin
            if (found_r || (present_r && !hbad_r && live && (c_start[0] == handle_r))) begin
              found_nxt  = 1'b1;
              push_start = c_start[1];
              push_size  = c_size[1];
              push_kind  = c_kind[1];
            end
          end
          ffha_pkg::CMD_VALIDATE: begin
            if (!found_r && present_r && !hbad_r && live && (c_start[0] == handle_r)) begin
              found_nxt = 1'b1;
              hit_nxt   = c_kind[0];
            end
          end
          default: begin
          end
        endcase
        k_nxt = k_r + KW'(1);
        if (last) begin
          state_nxt     = ffha_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
          out_type_nxt  = '0;
          case (cmd_r)
            ffha_pkg::CMD_CREATE: begin
              if (found_nxt) begin
                out_status_nxt = ffha_pkg::ST_OK;
                out_res_nxt    = res_nxt;
                count_nxt      = count_r + CW'(1);
              end else begin
                out_status_nxt = ffha_pkg::ST_NOSPACE;
              end
            end
            ffha_pkg::CMD_DELETE: begin
              if (found_nxt) begin
                out_status_nxt = ffha_pkg::ST_OK;
                count_nxt      = count_r - CW'(1);
              end else begin
                out_status_nxt = ffha_pkg::ST_NOTFOUND;
              end
            end
            ffha_pkg::CMD_VALIDATE: begin
              if (!present_r) begin
                out_status_nxt = ffha_pkg::ST_NULL;
              end else if (found_nxt) begin
                out_status_nxt = ffha_pkg::ST_OK;
                out_type_nxt   = hit_nxt;
              end else begin
                out_status_nxt = ffha_pkg::ST_INVALID;
              end
            end
            default: begin
              out_status_nxt = ffha_pkg::ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r        <= end_nxt;
    res_r        <= res_nxt;
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
    out_type_r   <= out_type_nxt;
    if (shift) begin
      carry_start_r <= c_start[0];
      carry_size_r  <= c_size[0];
      carry_kind_r  <= c_kind[0];
    end
    if (accept) begin
      cmd_r     <= ffha_pkg::cmd_t'(in_cmd);
      kind_r    <= in_alloc_type;
      size_r    <= in_payload_size;
      handle_r  <= AW'(handle_ext);
      hbad_r    <= (handle_ext >> AW) != '0;
      present_r <= in_handle_present;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_res_r;
  assign out_found_type    = out_type_r;

endmodule

### sv/ffha_checker.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator port checker
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [ffha_pkg::STATUS_W-1:0] out_status,
  input logic [ffha_pkg::HANDLE_W-1:0] out_result_handle,
  input logic [ffha_pkg::KIND_W-1:0]   out_found_type
);

  `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid)
  `FFHA_ASSERT_SAME(a_strobe_idle, out_valid, !busy)
  `FFHA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `FFHA_ASSERT_SAME(a_done_strobe, $fell(busy), out_valid)
  `FFHA_ASSERT_SAME(a_fail_zero, out_valid && (out_status != ffha_pkg::ST_OK), (out_result_handle == '0) && (out_found_type == '0))

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_result_handle (out_result_handle),
  .out_found_type    (out_found_type)
);
